// ----- src/assert_macros.svh -----
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define ASSERT_CLKD(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/gci_pkg.sv -----
// Package: widths, payload types and codes of the grid cell interpolator.
package gci_pkg;

   localparam int VALUE_BITS = 16;
   localparam int COORD_BITS = 16;
   localparam int FRAC_BITS  = 16;
   localparam int W_BITS     = FRAC_BITS + 1;
   localparam logic [W_BITS-1:0] WEIGHT_ONE = W_BITS'(1) << FRAC_BITS;

   localparam int DIV_STAGES = 4;
   localparam int DIV_STEP   = FRAC_BITS / DIV_STAGES;
   localparam int PIPE_WGT   = DIV_STAGES + 4;
   localparam int PIPE_BLEND = 4;
   localparam int PIPE_DEPTH = PIPE_WGT + PIPE_BLEND;

   typedef enum logic {
      MODE_LINEAR = 1'b0,
      MODE_SMOOTH = 1'b1
   } weight_mode_type;

   typedef struct packed {
      logic signed [VALUE_BITS-1:0] corner_bottom_left;
      logic signed [VALUE_BITS-1:0] corner_top_left;
      logic signed [VALUE_BITS-1:0] corner_bottom_right;
      logic signed [VALUE_BITS-1:0] corner_top_right;
      logic [COORD_BITS-1:0]        cell_x_min;
      logic [COORD_BITS-1:0]        cell_x_max;
      logic [COORD_BITS-1:0]        cell_z_min;
      logic [COORD_BITS-1:0]        cell_z_max;
      logic [COORD_BITS-1:0]        point_x;
      logic [COORD_BITS-1:0]        point_z;
   } req_payload_type;

   typedef struct packed {
      logic signed [VALUE_BITS-1:0] interpolated_value;
      logic                         degenerate_cell;
   } rsp_payload_type;

   typedef struct packed {
      logic signed [VALUE_BITS-1:0] bl;
      logic signed [VALUE_BITS-1:0] tl;
      logic signed [VALUE_BITS-1:0] br;
      logic signed [VALUE_BITS-1:0] tr;
   } corners_type;

endpackage

// ----- src/gci_req_if.sv -----
// Input channel: valid/ready plus one request word.
interface gci_req_if;
   logic                     valid;
   logic                     ready;
   gci_pkg::req_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ----- src/gci_rsp_if.sv -----
// Result channel: valid/ready plus one result word.
interface gci_rsp_if;
   logic                     valid;
   logic                     ready;
   gci_pkg::rsp_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ----- src/gci_csr_if.sv -----
// Configuration write channel carrying the weight mode bit.
interface gci_csr_if;
   logic valid;
   logic ready;
   logic data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ----- src/gci_weight.sv -----
// One axis: weight by pipelined restoring division, then optional smoothstep.
module gci_weight (
   input  logic                           clock,
   input  logic                           adv,
   input  gci_pkg::weight_mode_type       mode,
   input  logic [gci_pkg::COORD_BITS-1:0] lo,
   input  logic [gci_pkg::COORD_BITS-1:0] hi,
   input  logic [gci_pkg::COORD_BITS-1:0] pos,
   output logic [gci_pkg::W_BITS-1:0]     w_out,
   output logic                           degen_out
);
   import gci_pkg::*;

   localparam int NW = COORD_BITS + FRAC_BITS;

   typedef struct packed {
      logic [COORD_BITS-1:0] rem;
      logic [FRAC_BITS-1:0]  low;
      logic [FRAC_BITS-1:0]  quo;
   } div_type;

   typedef struct packed {
      logic              use_div;
      logic [W_BITS-1:0] fixed;
      logic              degen;
   } wctl_type;

   function automatic div_type div_steps(div_type a, logic [COORD_BITS-1:0] span);
      div_type           r;
      logic [COORD_BITS:0] t;
      logic              qb;
      r = a;
      for (int i = 0; i < DIV_STEP; i++) begin
         t = {r.rem, r.low[FRAC_BITS-1]};
         r.low = r.low << 1;
         qb = (t >= {1'b0, span});
         if (qb) begin
            t = t - {1'b0, span};
         end
         r.rem = t[COORD_BITS-1:0];
         r.quo = {r.quo[FRAC_BITS-2:0], qb};
      end
      return r;
   endfunction

   div_type               div_ff [DIV_STAGES+1];
   div_type               div_in;
   wctl_type              ctl_ff [DIV_STAGES+1];
   wctl_type              ctl_in;
   logic [COORD_BITS-1:0] span_ff [DIV_STAGES];
   logic [COORD_BITS-1:0] span_in;
   logic [NW-1:0]         num;

   logic [W_BITS-1:0]     w6_ff, w6_in;
   logic [2*W_BITS-1:0]   sq_ff;
   logic                  deg6_ff;
   logic [W_BITS-1:0]     w7_ff;
   logic [2*W_BITS:0]     prod_ff;
   logic                  deg7_ff;
   logic [W_BITS-1:0]     w2r;
   logic [W_BITS:0]       kk;
   logic [2*W_BITS:0]     rnd;
   logic [W_BITS-1:0]     smooth;
   logic [W_BITS-1:0]     w_ff, w_in;
   logic                  degen_ff;

   // entry stage: bounds checks and dividend setup
   always_comb begin
      span_in = hi - lo;
      num = {(hi - pos), {FRAC_BITS{1'b0}}} + NW'(span_in >> 1);
      div_in.rem = num[NW-1:FRAC_BITS];
      div_in.low = num[FRAC_BITS-1:0];
      div_in.quo = '0;
      ctl_in.degen = (hi <= lo);
      ctl_in.use_div = 1'b0;
      ctl_in.fixed = WEIGHT_ONE;
      if (hi <= lo || pos <= lo) begin
         ctl_in.fixed = WEIGHT_ONE;
      end else if (pos >= hi) begin
         ctl_in.fixed = '0;
      end else begin
         ctl_in.use_div = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         div_ff[0]  <= div_in;
         ctl_ff[0]  <= ctl_in;
         span_ff[0] <= span_in;
         for (int k = 0; k < DIV_STAGES; k++) begin
            div_ff[k+1]  <= div_steps(div_ff[k], span_ff[k]);
            ctl_ff[k+1]  <= ctl_ff[k];
         end
         for (int k = 1; k < DIV_STAGES; k++) begin
            span_ff[k] <= span_ff[k-1];
         end
      end
   end

   // weight select and square, then smoothstep product, then round and clamp
   assign w6_in = ctl_ff[DIV_STAGES].use_div ? {1'b0, div_ff[DIV_STAGES].quo}
                                             : ctl_ff[DIV_STAGES].fixed;
   assign w2r = W_BITS'((sq_ff + (2*W_BITS)'(1 << (FRAC_BITS-1))) >> FRAC_BITS);
   assign kk = (W_BITS+1)'(3) * (W_BITS+1)'(WEIGHT_ONE) - ((W_BITS+1)'(w6_ff) << 1);
   assign rnd = (prod_ff + (2*W_BITS+1)'(1 << (FRAC_BITS-1))) >> FRAC_BITS;
   assign smooth = (rnd > (2*W_BITS+1)'(WEIGHT_ONE)) ? WEIGHT_ONE : W_BITS'(rnd);
   assign w_in = (mode == MODE_SMOOTH) ? smooth : w7_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         w6_ff    <= w6_in;
         sq_ff    <= w6_in * w6_in;
         deg6_ff  <= ctl_ff[DIV_STAGES].degen;
         w7_ff    <= w6_ff;
         prod_ff  <= (2*W_BITS+1)'(w2r) * (2*W_BITS+1)'(kk);
         deg7_ff  <= deg6_ff;
         w_ff     <= w_in;
         degen_ff <= deg7_ff;
      end
   end

   assign w_out = w_ff;
   assign degen_out = degen_ff;
endmodule

// ----- src/gci_blend.sv -----
// Two x blends, then the z blend split in two partial products, then rounding.
module gci_blend (
   input  logic                                  clock,
   input  logic                                  adv,
   input  gci_pkg::corners_type                  corners,
   input  logic [gci_pkg::W_BITS-1:0]            wx,
   input  logic [gci_pkg::W_BITS-1:0]            wz,
   input  logic                                  degen_in,
   output logic signed [gci_pkg::VALUE_BITS-1:0] value_out,
   output logic                                  degen_out
);
   import gci_pkg::*;

   localparam int BW = VALUE_BITS + FRAC_BITS + 2;
   localparam int DW = BW + 1;
   localparam int LW = DW / 2;
   localparam int HW = DW - LW;
   localparam int VW = VALUE_BITS + 2 * FRAC_BITS + 2;

   logic signed [VALUE_BITS:0] db, dt;
   logic signed [W_BITS:0]     wxs, wzs;
   logic signed [BW-1:0]       bot_ff, top1_ff, bot_in, top_in;
   logic signed [DW-1:0]       diff_ff;
   logic signed [BW-1:0]       top2_ff, top3_ff;
   logic [W_BITS-1:0]          wz1_ff, wz2_ff;
   logic [LW+W_BITS-1:0]       pl_ff;
   logic signed [HW+W_BITS:0]  ph_ff;
   logic signed [VW-1:0]       v;
   logic signed [VALUE_BITS-1:0] value_ff;
   logic [PIPE_BLEND-1:0]      deg_ff;

   assign wxs = $signed({1'b0, wx});
   assign wzs = $signed({1'b0, wz2_ff});
   assign db = $signed({corners.bl[VALUE_BITS-1], corners.bl})
             - $signed({corners.br[VALUE_BITS-1], corners.br});
   assign dt = $signed({corners.tl[VALUE_BITS-1], corners.tl})
             - $signed({corners.tr[VALUE_BITS-1], corners.tr});
   // q*1.0 + (p-q)*w with 16 fraction bits
   assign bot_in = (BW'(corners.br) <<< FRAC_BITS) + BW'(db * wxs);
   assign top_in = (BW'(corners.tr) <<< FRAC_BITS) + BW'(dt * wxs);

   // top*1.0 + (bottom-top)*wz with 32 fraction bits, plus half for rounding
   assign v = (VW'(top3_ff) <<< FRAC_BITS) + (VW'(ph_ff) <<< LW)
            + VW'($signed({1'b0, pl_ff})) + (VW'(1) <<< (2*FRAC_BITS-1));

   always_ff @(posedge clock) begin
      if (adv) begin
         bot_ff   <= bot_in;
         top1_ff  <= top_in;
         wz1_ff   <= wz;
         diff_ff  <= DW'(bot_ff) - DW'(top1_ff);
         top2_ff  <= top1_ff;
         wz2_ff   <= wz1_ff;
         pl_ff    <= (LW+W_BITS)'(diff_ff[LW-1:0]) * (LW+W_BITS)'(wz2_ff);
         ph_ff    <= (HW+W_BITS+1)'($signed(diff_ff[DW-1:LW]) * wzs);
         top3_ff  <= top2_ff;
         value_ff <= v[2*FRAC_BITS+VALUE_BITS-1:2*FRAC_BITS];
         deg_ff   <= {deg_ff[PIPE_BLEND-2:0], degen_in};
      end
   end

   assign value_out = value_ff;
   assign degen_out = deg_ff[PIPE_BLEND-1];
endmodule

// ----- src/grid_cell_interpolator_core.sv -----
// Top level of the grid cell interpolator: handshake, mode register, pipeline.
//
// Interpolates a value inside a rectangular grid cell from its four corners.
// Fully pipelined with 12 register stages: one word is taken per clock while
// the pipeline advances (8 stages of weight computation, where a 16-step
// restoring divider runs 4 quotient bits per stage, then 4 stages of
// blending). The whole pipeline holds when the result word is not taken, so
// req.ready falls only while a finished result waits on rsp.ready. The mode
// register (1 = smoothstep weights, reset value) is written over csr, which is
// always ready; write it only while the pipeline is empty. degenerate_cell
// flags a cell with zero or negative width or height; that axis weight is 1.
module grid_cell_interpolator_core (
   input logic    clock,
   input logic    reset,
   gci_req_if.sink   req,
   gci_rsp_if.source rsp,
   gci_csr_if.sink   csr
);
   import gci_pkg::*;

   weight_mode_type       mode_ff;
   logic [PIPE_DEPTH-1:0] vld_ff;
   logic                  adv;
   corners_type           crn_ff [PIPE_WGT];
   corners_type           crn_in;
   logic [W_BITS-1:0]     wx, wz;
   logic                  degx, degz;
   logic signed [VALUE_BITS-1:0] blend_value;
   logic                  blend_degen;

   // mode register
   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_SMOOTH;
      end else if (csr.valid) begin
         mode_ff <= weight_mode_type'(csr.data);
      end
   end

   // global advance: everything moves unless the output word is stuck
   assign adv = !vld_ff[PIPE_DEPTH-1] || rsp.ready;
   assign req.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[PIPE_DEPTH-2:0], req.valid};
      end
   end

   // corners ride alongside the weight stages
   assign crn_in.bl = req.data.corner_bottom_left;
   assign crn_in.tl = req.data.corner_top_left;
   assign crn_in.br = req.data.corner_bottom_right;
   assign crn_in.tr = req.data.corner_top_right;

   always_ff @(posedge clock) begin
      if (adv) begin
         crn_ff[0] <= crn_in;
         for (int k = 1; k < PIPE_WGT; k++) begin
            crn_ff[k] <= crn_ff[k-1];
         end
      end
   end

   gci_weight u_wx (
      .clock     (clock),
      .adv       (adv),
      .mode      (mode_ff),
      .lo        (req.data.cell_x_min),
      .hi        (req.data.cell_x_max),
      .pos       (req.data.point_x),
      .w_out     (wx),
      .degen_out (degx)
   );

   gci_weight u_wz (
      .clock     (clock),
      .adv       (adv),
      .mode      (mode_ff),
      .lo        (req.data.cell_z_min),
      .hi        (req.data.cell_z_max),
      .pos       (req.data.point_z),
      .w_out     (wz),
      .degen_out (degz)
   );

   gci_blend u_blend (
      .clock     (clock),
      .adv       (adv),
      .corners   (crn_ff[PIPE_WGT-1]),
      .wx        (wx),
      .wz        (wz),
      .degen_in  (degx | degz),
      .value_out (blend_value),
      .degen_out (blend_degen)
   );

   assign rsp.data = {blend_value, blend_degen};
   assign rsp.valid = vld_ff[PIPE_DEPTH-1];
endmodule

// ----- src/gci_checker.sv -----
// Port-level checker for the interpolator core, bound to the top level.
`include "assert_macros.svh"

module gci_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_ready,
   input logic                                  rsp_valid,
   input logic                                  rsp_ready,
   input logic signed [gci_pkg::VALUE_BITS-1:0] rsp_value,
   input logic                                  rsp_degen
);
   logic                         stalled;
   logic [gci_pkg::VALUE_BITS:0] rsp_word;

   assign stalled  = rsp_valid && !rsp_ready;
   assign rsp_word = {rsp_value, rsp_degen};

   `ASSERT_CLKD(a_rsp_hold, clock, reset, stalled |=> rsp_valid, "result word dropped in stall")
   `ASSERT_CLKD(a_rsp_stable, clock, reset, stalled |=> $stable(rsp_word), "stalled result changed")
   `ASSERT_CLKD(a_ready_rule, clock, reset, req_ready == !stalled, "ready not tied to stall")
   `ASSERT_ALWAYS(a_reset_empty, clock, $past(reset) |-> !rsp_valid, "result valid after reset")
endmodule

bind grid_cell_interpolator_core gci_checker u_gci_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req.ready),
   .rsp_valid (rsp.valid),
   .rsp_ready (rsp.ready),
   .rsp_value (rsp.data.interpolated_value),
   .rsp_degen (rsp.data.degenerate_cell)
);
